// ----- design/pfde_pkg.sv -----
// ----------------------------------------------------------------------------
// Page frame buffer draw engine package
// Shared types, codes and default sizes for the draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int unsigned DefColumns = 128;
  localparam int unsigned DefPages   = 8;
  localparam int unsigned MaxWords   = 16;

  // Operation codes.
  localparam logic [2:0] OpDraw    = 3'd0;
  localparam logic [2:0] OpRead    = 3'd1;
  localparam logic [2:0] OpRect    = 3'd2;
  localparam logic [2:0] OpScreen  = 3'd3;
  localparam logic [2:0] OpRefresh = 3'd4;

  // Result status codes.
  localparam logic [2:0] StOn        = 3'd0;
  localparam logic [2:0] StOff       = 3'd1;
  localparam logic [2:0] StError     = 3'd2;
  localparam logic [2:0] StIdle      = 3'd3;
  localparam logic [2:0] StSuccess   = 3'd4;
  localparam logic [2:0] StUnchanged = 3'd5;

  // Draw modes.
  localparam logic [1:0] ModeNormal  = 2'd0;
  localparam logic [1:0] ModeInverse = 2'd1;
  localparam logic [1:0] ModeXor     = 2'd2;

  // Datapath commands issued by the controller.
  typedef enum logic [2:0] {
    CmdNone,
    CmdRead,
    CmdWritePix,
    CmdWriteByte,
    CmdSumRead,
    CmdWordRead
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  page;
    logic [7:0]  col;
    logic [2:0]  bit_sel;
    logic [7:0]  fill_byte;
    logic        set_pixel;
    logic [1:0]  draw_mode;
    logic        overwrite;
    logic        sum_clear;
    logic        sum_write;
  } dp_cmd_t;

  typedef struct packed {
    logic        rd_valid;
    logic        pix_bit;
    logic [2:0]  pix_status;
    logic [7:0]  sum;
    logic [7:0]  stored_sum;
    logic        word_valid;
    logic [63:0] word;
  } dp_stat_t;

  // Draw one pixel into a byte; returns the new byte and the status.
  function automatic logic [10:0] draw_bit(input logic [7:0] b, input logic [2:0] bs,
                                           input logic set, input logic [1:0] mode,
                                           input logic over);
    logic [7:0] m;
    logic [7:0] nb;
    logic [2:0] st;
    m  = 8'd1 << bs;
    nb = b;
    st = StIdle;
    if (set || over) begin
      case (mode)
        ModeNormal: begin
          nb = set ? (b | m) : (b & ~m);
          st = set ? StOn : StOff;
        end
        ModeInverse: begin
          nb = set ? (b & ~m) : (b | m);
          st = set ? StOff : StOn;
        end
        ModeXor: begin
          if (set) begin
            nb = b ^ m;
            st = ((nb & m) != 8'd0) ? StOn : StOff;
          end
        end
        default: st = StIdle;
      endcase
    end
    return {st, nb};
  endfunction

endpackage

// ----- design/page_framebuffer_draw_engine.sv -----
// ----------------------------------------------------------------------------
// Page frame buffer draw engine
// Monochrome page frame buffer with pixel, rectangle, fill and refresh ops.
// ----------------------------------------------------------------------------
// channel | dir | payload
// s_axis  | in  | opcode, x/y start/end, flags, page_select, force_req
// m_axis  | out | status, page_index, column_group, data_word; last in tlast
//
// Pixel draw and pixel read first read the byte, then write the drawn pixel
// or take the read bit; rectangle fill reads and writes each clipped pixel in
// turn and screen fill writes one byte per cycle, Columns*Pages in all. Refresh
// reads every column of the page, waits, decides, then reads each data word.
// After reset the frame is cleared, all Columns*Pages bytes, with tready low.
// A stalled output holds the block before the next item is taken.
module page_framebuffer_draw_engine #(
  parameter int unsigned Columns = pfde_pkg::DefColumns,
  parameter int unsigned Pages   = pfde_pkg::DefPages
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], x_start[13:3], y_start[24:14], x_end[35:25], y_end[46:36],
  // set_pixel[47], draw_mode[49:48], overwrite[50], page_select[53:51],
  // force_req[54], zeros[55]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], page_index[5:3], column_group[9:6], data_word[73:10], zeros
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import pfde_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [2:0]  status, page_index;
  logic [3:0]  column_group;
  logic [63:0] data_word;

  pfde_ctrl #(.Columns(Columns), .Pages(Pages)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tdata[2:0]),
    .x_start_i(s_axis_tdata[13:3]), .y_start_i(s_axis_tdata[24:14]),
    .x_end_i(s_axis_tdata[35:25]), .y_end_i(s_axis_tdata[46:36]),
    .set_pixel_i(s_axis_tdata[47]), .draw_mode_i(s_axis_tdata[49:48]),
    .overwrite_i(s_axis_tdata[50]), .page_select_i(s_axis_tdata[53:51]),
    .force_req_i(s_axis_tdata[54]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(status), .page_index_o(page_index), .column_group_o(column_group),
    .data_word_o(data_word), .last_o(m_axis_tlast),
    .cmd_o(cmd), .stat_i(stat)
  );

  pfde_datapath #(.Columns(Columns), .Pages(Pages)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat)
  );

  assign m_axis_tdata = {6'd0, data_word, column_group, page_index, status};

endmodule

// ----- design/pfde_datapath.sv -----
// ----------------------------------------------------------------------------
// Draw engine datapath
// Frame memory, page checksum registers and data word assembly.
// ----------------------------------------------------------------------------
module pfde_datapath #(
  parameter int unsigned Columns = 128,
  parameter int unsigned Pages   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfde_pkg::dp_cmd_t  cmd_i,
  output pfde_pkg::dp_stat_t stat_o
);
  import pfde_pkg::*;

  localparam int unsigned Depth = Columns * Pages;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW    = (Pages > 1) ? $clog2(Pages) : 1;

  logic [7:0]  mem [Depth];
  logic [7:0]  rd_data_q;
  logic        rd_valid_q;
  logic [2:0]  bit_q;
  logic [AW-1:0] addr;
  logic [10:0] drawn;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  sums_q [Pages];
  logic [63:0] word_q, word_d;
  logic [2:0]  wcnt_q;
  logic        word_valid_q;
  logic        word_mode_q;

  assign addr  = AW'(32'(cmd_i.page) * Columns + 32'(cmd_i.col));
  assign drawn = draw_bit(rd_data_q, cmd_i.bit_sel, cmd_i.set_pixel,
                          cmd_i.draw_mode, cmd_i.overwrite);

  // Memory: one write or one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == CmdWritePix) begin
      mem[addr] <= drawn[7:0];
    end else if (cmd_i.cmd == CmdWriteByte) begin
      mem[addr] <= cmd_i.fill_byte;
    end else begin
      rd_data_q <= mem[addr];
    end
  end

  // Read tracking, checksum and word shift register.
  always_comb begin
    sum_d  = sum_q;
    word_d = word_q;
    if (cmd_i.sum_clear) begin
      sum_d = 8'd0;
    end else if (rd_valid_q && !word_mode_q) begin
      sum_d = sum_q ^ rd_data_q;
    end
    if (rd_valid_q && word_mode_q) begin
      word_d = {rd_data_q, word_q[63:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q   <= 1'b0;
      word_mode_q  <= 1'b0;
      bit_q        <= 3'd0;
      word_q       <= '0;
      wcnt_q       <= 3'd0;
      word_valid_q <= 1'b0;
      sum_q        <= 8'd0;
      for (int i = 0; i < Pages; i++) sums_q[i] <= 8'd0;
    end else begin
      rd_valid_q   <= (cmd_i.cmd == CmdRead) || (cmd_i.cmd == CmdSumRead) ||
                      (cmd_i.cmd == CmdWordRead);
      word_mode_q  <= (cmd_i.cmd == CmdWordRead);
      bit_q        <= cmd_i.bit_sel;
      sum_q        <= sum_d;
      word_q       <= word_d;
      word_valid_q <= 1'b0;
      if (cmd_i.sum_clear) begin
        wcnt_q <= 3'd0;
      end else if (rd_valid_q && word_mode_q) begin
        wcnt_q <= wcnt_q + 3'd1;
        word_valid_q <= (wcnt_q == 3'd7);
      end
      if (cmd_i.sum_write) sums_q[cmd_i.page[PW-1:0]] <= sum_q;
    end
  end

  always_comb begin
    stat_o.rd_valid   = rd_valid_q;
    stat_o.pix_bit    = rd_data_q[bit_q];
    stat_o.pix_status = drawn[10:8];
    stat_o.sum        = sum_q;
    stat_o.stored_sum = sums_q[cmd_i.page[PW-1:0]];
    stat_o.word_valid = word_valid_q;
    stat_o.word       = word_q;
  end

endmodule

// ----- design/pfde_ctrl.sv -----
// ----------------------------------------------------------------------------
// Draw engine controller
// Sequences pixel, rectangle, screen and refresh operations.
// ----------------------------------------------------------------------------
module pfde_ctrl #(
  parameter int unsigned Columns = 128,
  parameter int unsigned Pages   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [10:0] x_start_i,
  input  logic signed [10:0] y_start_i,
  input  logic signed [10:0] x_end_i,
  input  logic signed [10:0] y_end_i,
  input  logic               set_pixel_i,
  input  logic [1:0]         draw_mode_i,
  input  logic               overwrite_i,
  input  logic [2:0]         page_select_i,
  input  logic               force_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [2:0]         page_index_o,
  output logic [3:0]         column_group_o,
  output logic [63:0]        data_word_o,
  output logic               last_o,
  output pfde_pkg::dp_cmd_t  cmd_o,
  input  pfde_pkg::dp_stat_t stat_i
);
  import pfde_pkg::*;

  localparam int unsigned Height = Pages * 8;
  localparam int unsigned Words0 = (Columns + 7) / 8;
  localparam int unsigned Words  = (Words0 > MaxWords) ? MaxWords : Words0;
  localparam logic signed [11:0] ColsS   = 12'(Columns);
  localparam logic signed [11:0] HeightS = 12'(Height);

  typedef enum logic [3:0] {
    SIdle, SPixRd, SPixWr, SRead, SRect, SRectWr, SScreen,
    SSum, SSumWait, SDecide, SWord, SWordWait, SOut
  } state_e;

  state_e      state_q;
  logic [2:0]  op_q;
  logic signed [11:0] x0_q, x1_q, y1_q, x_q, y_q;
  logic        set_q, over_q, force_q;
  logic [1:0]  mode_q;
  logic [2:0]  page_q;
  logic [8:0]  col_q;
  logic [7:0]  pg_q;
  logic [3:0]  grp_q;
  logic        ov_q;
  logic [2:0]  st_q;
  logic [3:0]  og_q;
  logic [63:0] ow_q;
  logic        olast_q, o_word_q;
  logic        init_q;

  logic signed [11:0] xs, ys, xe, ye;
  logic        pix_ok;
  assign xs = 12'(x_start_i);
  assign ys = 12'(y_start_i);
  assign xe = 12'(x_end_i);
  assign ye = 12'(y_end_i);
  assign pix_ok = (xs >= 0) && (xs < 12'(Columns)) && (ys >= 0) && (ys < 12'(Height));

  assign in_ready_o = (state_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign page_index_o = o_word_q ? page_q : 3'd0;
  assign column_group_o = og_q;
  assign data_word_o = ow_q;
  assign last_o = olast_q;

  // Commands to the datapath. The checksum is cleared while idle; the stored
  // checksum is updated when a refresh decides on a changed, unforced sum.
  always_comb begin
    cmd_o = '0;
    cmd_o.cmd = CmdNone;
    cmd_o.set_pixel = set_q;
    cmd_o.draw_mode = mode_q;
    cmd_o.overwrite = over_q;
    cmd_o.page = {5'd0, page_q};
    cmd_o.fill_byte = set_q ? 8'hFF : 8'h00;
    cmd_o.sum_clear = (state_q == SIdle);
    cmd_o.sum_write = (state_q == SDecide) && !force_q &&
                      (stat_i.sum != stat_i.stored_sum);
    case (state_q)
      SPixRd, SRect: begin
        cmd_o.cmd = CmdRead;
        cmd_o.page = 8'(y_q >>> 3);
        cmd_o.col = 8'(x_q);
        cmd_o.bit_sel = y_q[2:0];
      end
      SPixWr, SRectWr: begin
        cmd_o.cmd = CmdWritePix;
        cmd_o.page = 8'(y_q >>> 3);
        cmd_o.col = 8'(x_q);
        cmd_o.bit_sel = y_q[2:0];
      end
      SRead: begin
        cmd_o.page = 8'(y_q >>> 3);
        cmd_o.bit_sel = y_q[2:0];
      end
      SScreen: begin
        cmd_o.cmd = CmdWriteByte;
        cmd_o.page = pg_q;
        cmd_o.col = col_q[7:0];
      end
      SSum: begin
        cmd_o.cmd = CmdSumRead;
        cmd_o.col = col_q[7:0];
      end
      SWord: begin
        cmd_o.cmd = (col_q < 9'(Columns)) ? CmdWordRead : CmdNone;
        cmd_o.col = col_q[7:0];
      end
      default: cmd_o.cmd = CmdNone;
    endcase
  end

  // Controller state and result registers. After reset the frame is cleared
  // by a screen fill pass with zeros that gives no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SScreen;
      ov_q     <= 1'b0;
      set_q    <= 1'b0;
      col_q    <= 9'd0;
      pg_q     <= 8'd0;
      init_q   <= 1'b1;
      page_q   <= 3'd0;
      st_q     <= StIdle;
      og_q     <= 4'd0;
      ow_q     <= '0;
      olast_q  <= 1'b0;
      o_word_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (in_valid_i && in_ready_o) begin
            op_q <= opcode_i; set_q <= set_pixel_i; mode_q <= draw_mode_i;
            over_q <= overwrite_i; page_q <= page_select_i; force_q <= force_req_i;
            x_q <= xs; y_q <= ys;
            og_q <= 4'd0; ow_q <= '0; olast_q <= 1'b1; o_word_q <= 1'b0;
            st_q <= StError;
            case (opcode_i)
              OpDraw, OpRead: begin
                if (!pix_ok) ov_q <= 1'b1;
                else state_q <= SPixRd;
              end
              OpRect: begin
                if (ys >= HeightS || ye < 0 || ys > ye ||
                    xs >= ColsS || xe < 0 || xs > xe) begin
                  ov_q <= 1'b1;
                end else begin
                  x0_q <= (xs < 0) ? 12'sd0 : xs;
                  x_q  <= (xs < 0) ? 12'sd0 : xs;
                  y_q  <= (ys < 0) ? 12'sd0 : ys;
                  x1_q <= (xe >= ColsS) ? ColsS - 12'sd1 : xe;
                  y1_q <= (ye >= HeightS) ? HeightS - 12'sd1 : ye;
                  state_q <= SRect;
                end
              end
              OpScreen: begin
                col_q <= 9'd0; pg_q <= 8'd0; state_q <= SScreen;
              end
              OpRefresh: begin
                if (32'(page_select_i) >= Pages) ov_q <= 1'b1;
                else begin
                  col_q <= 9'd0; state_q <= SSum;
                end
              end
              default: ov_q <= 1'b1;
            endcase
          end
        end
        SPixRd: state_q <= (op_q == OpRead) ? SRead : SPixWr;
        SRead: begin
          st_q <= stat_i.pix_bit ? StOn : StOff;
          ov_q <= 1'b1; state_q <= SIdle;
        end
        SPixWr: begin
          st_q <= stat_i.pix_status; ov_q <= 1'b1; state_q <= SIdle;
        end
        SRect: state_q <= SRectWr;
        SRectWr: begin
          if (x_q == x1_q) begin
            x_q <= x0_q;
            if (y_q == y1_q) begin
              st_q <= StSuccess; ov_q <= 1'b1; state_q <= SIdle;
            end else begin
              y_q <= y_q + 12'sd1; state_q <= SRect;
            end
          end else begin
            x_q <= x_q + 12'sd1; state_q <= SRect;
          end
        end
        SScreen: begin
          if (col_q == 9'(Columns - 1)) begin
            col_q <= 9'd0;
            if (pg_q == 8'(Pages - 1)) begin
              init_q <= 1'b0;
              state_q <= SIdle;
              if (!init_q) begin
                st_q <= StSuccess; ov_q <= 1'b1;
              end
            end else pg_q <= pg_q + 8'd1;
          end else col_q <= col_q + 9'd1;
        end
        SSum: begin
          if (col_q == 9'(Columns - 1)) state_q <= SSumWait;
          col_q <= col_q + 9'd1;
        end
        SSumWait: state_q <= SDecide;
        SDecide: begin
          col_q <= 9'd0; grp_q <= 4'd0;
          if (stat_i.sum == stat_i.stored_sum && !force_q) begin
            st_q <= StUnchanged; ov_q <= 1'b1; state_q <= SIdle;
          end else state_q <= SWord;
        end
        SWord: begin
          col_q <= col_q + 9'd1;
          if (col_q[2:0] == 3'd7) state_q <= SWordWait;
        end
        SWordWait: begin
          if (stat_i.word_valid || col_q > 9'(Columns)) state_q <= SOut;
        end
        SOut: begin
          if (!ov_q) begin
            ov_q <= 1'b1; st_q <= StSuccess; o_word_q <= 1'b1;
            og_q <= grp_q;
            ow_q <= (col_q > 9'(Columns)) ?
                    (stat_i.word >> (8 * (32'(col_q) - Columns))) : stat_i.word;
            olast_q <= (32'(grp_q) == Words - 1);
            if (32'(grp_q) == Words - 1) state_q <= SIdle;
            else begin
              grp_q <= grp_q + 4'd1; state_q <= SWord;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule
